// ----- design/mcbp_pkg.sv -----
// Shared types, constants and address helpers for the multi-channel byte pipe.
package mcbp_pkg;

   localparam int PIPE_COUNT     = 8;
   localparam int BUFFER_BYTES   = 512;
   localparam int READ_BURST_MAX = 64;

   localparam int CH_BITS    = 3;
   localparam int LEN_BITS   = 10;
   localparam int PTR_BITS   = $clog2(BUFFER_BYTES);
   localparam int FILL_BITS  = $clog2(BUFFER_BYTES + 1);
   localparam int RUN_BITS   = $clog2(READ_BURST_MAX + 1);
   localparam int STORE_DEPTH = PIPE_COUNT * BUFFER_BYTES;
   localparam int ADDR_BITS  = $clog2(STORE_DEPTH);

   localparam logic [1:0] ACT_OPEN  = 2'd0;
   localparam logic [1:0] ACT_CLOSE = 2'd1;
   localparam logic [1:0] ACT_WRITE = 2'd2;
   localparam logic [1:0] ACT_READ  = 2'd3;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_BAD_CHAN = 3'd1;
   localparam logic [2:0] ST_NO_FREE  = 3'd2;
   localparam logic [2:0] ST_NO_ROOM  = 3'd3;
   localparam logic [2:0] ST_EMPTY    = 3'd4;

   typedef struct packed {
      logic [1:0]          action;
      logic [CH_BITS-1:0]  channel;
      logic [LEN_BITS-1:0] length;
      logic [7:0]          data;
   } req_type;

   typedef struct packed {
      logic [2:0]          status;
      logic [CH_BITS-1:0]  pipe_id;
      logic [7:0]          byte_out;
      logic [LEN_BITS-1:0] count;
      logic                last;
   } rsp_type;

   typedef struct packed {
      logic                 we;
      logic [ADDR_BITS-1:0] waddr;
      logic [7:0]           wdata;
      logic                 re;
      logic [ADDR_BITS-1:0] raddr;
   } store_req_type;

   function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] ptr);
      logic [PTR_BITS:0] sum;
      sum = {1'b0, ptr} + (PTR_BITS+1)'(1);
      if (sum == (PTR_BITS+1)'(BUFFER_BYTES)) begin
         return '0;
      end
      return sum[PTR_BITS-1:0];
   endfunction

   // The step never exceeds the buffer size, so one conditional subtract wraps it.
   function automatic logic [PTR_BITS-1:0] ptr_add(input logic [PTR_BITS-1:0] ptr,
                                                   input logic [RUN_BITS-1:0] step);
      logic [PTR_BITS+1:0] sum;
      sum = (PTR_BITS+2)'(ptr) + (PTR_BITS+2)'(step);
      if (sum >= (PTR_BITS+2)'(BUFFER_BYTES)) begin
         sum = sum - (PTR_BITS+2)'(BUFFER_BYTES);
      end
      return sum[PTR_BITS-1:0];
   endfunction

   function automatic logic [ADDR_BITS-1:0] store_addr(input logic [CH_BITS-1:0] ch,
                                                       input logic [PTR_BITS-1:0] ptr);
      return ADDR_BITS'(ADDR_BITS'(ch) * ADDR_BITS'(BUFFER_BYTES) + ADDR_BITS'(ptr));
   endfunction

endpackage

// ----- design/multi_channel_byte_pipe.sv -----
// Top level of the multi-channel byte pipe: control sequencer and byte store.
//
//   Channel  Ports                          Moves
//   request  req_valid/req_ready/req_item   open, close, write byte or read request
//   response rsp_valid/rsp_ready/rsp_item   status, pipe id, byte, count, last
//
// A new open, close or write request is taken every cycle while the response
// register is free or being drained. A read request holds off further requests
// until its last byte is out: the store's registered read port delivers one byte
// per cycle into the response register.
// Reset is synchronous and clears the pipe table and burst state; the byte store needs
// no clearing because only written bytes are ever read.
// A stalled response stops both the store read sequencer and request acceptance.
module multi_channel_byte_pipe
   import mcbp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_item,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_item
);

   store_req_type store_req;
   logic [7:0]    store_rdata;

   mcbp_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_item    (rsp_item),
      .store_req   (store_req),
      .store_rdata (store_rdata)
   );

   mcbp_store u_store (
      .clock     (clock),
      .store_req (store_req),
      .rdata     (store_rdata)
   );

endmodule

// ----- design/mcbp_store.sv -----
// Byte store shared by all pipes: one write port and one registered read port.
module mcbp_store
   import mcbp_pkg::*;
(
   input  logic          clock,
   input  store_req_type store_req,
   output logic [7:0]    rdata
);

   logic [7:0] mem [STORE_DEPTH];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (store_req.we) begin
         mem[store_req.waddr] <= store_req.wdata;
      end
      if (store_req.re) begin
         rdata_ff <= mem[store_req.raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- design/mcbp_ctrl.sv -----
// Pipe table, burst tracking, read sequencer and response register.
module mcbp_ctrl
   import mcbp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  req_type       req_item,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_type       rsp_item,
   output store_req_type store_req,
   input  logic [7:0]    store_rdata
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_READ = 1'b1;

   logic                  state_ff, state_in;
   logic [PIPE_COUNT-1:0] in_use_ff, in_use_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff [PIPE_COUNT];
   logic [PTR_BITS-1:0]   wr_ptr_ff [PIPE_COUNT];
   logic [FILL_BITS-1:0]  fill_ff   [PIPE_COUNT];

   logic                  tbl_we;
   logic [CH_BITS-1:0]    tbl_widx;
   logic [PTR_BITS-1:0]   tbl_rp, tbl_wp;
   logic [FILL_BITS-1:0]  tbl_fill;

   logic [LEN_BITS-1:0]   burst_left_ff, burst_left_in;
   logic                  burst_acc_ff, burst_acc_in;
   logic [CH_BITS-1:0]    burst_ch_ff, burst_ch_in;

   logic [CH_BITS-1:0]    rd_ch_ff, rd_ch_in;
   logic [PTR_BITS-1:0]   rd_pos_ff, rd_pos_in;
   logic [RUN_BITS-1:0]   rd_cnt_ff, rd_cnt_in;
   logic [RUN_BITS-1:0]   iss_left_ff, iss_left_in;
   logic [RUN_BITS-1:0]   out_left_ff, out_left_in;
   logic                  pend_ff, pend_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_item_ff, rsp_item_in;

   logic                  slot_free, accept, issue, load_rd;
   logic [CH_BITS-1:0]    idx, free_idx;
   logic                  free_found, chan_ok;
   logic [PTR_BITS-1:0]   rp_cur, wp_cur;
   logic [FILL_BITS-1:0]  fill_cur;
   logic [LEN_BITS-1:0]   run_min;
   logic [RUN_BITS-1:0]   run_len;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && slot_free;
   assign accept    = req_valid && req_ready;

   // Burst continuation bytes go to the burst's pipe, everything else to the item's channel.
   assign idx = (req_item.action == ACT_WRITE && burst_left_ff != '0) ? burst_ch_ff
                                                                      : req_item.channel;
   assign rp_cur   = rd_ptr_ff[idx];
   assign wp_cur   = wr_ptr_ff[idx];
   assign fill_cur = fill_ff[idx];
   assign chan_ok  = (32'(req_item.channel) < PIPE_COUNT) && in_use_ff[req_item.channel];

   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = PIPE_COUNT - 1; i >= 0; i--) begin
         if (!in_use_ff[i]) begin
            free_found = 1'b1;
            free_idx   = CH_BITS'(i);
         end
      end
   end

   always_comb begin
      run_min = (LEN_BITS'(fill_cur) < req_item.length) ? LEN_BITS'(fill_cur)
                                                         : req_item.length;
      if (run_min > LEN_BITS'(READ_BURST_MAX)) begin
         run_len = RUN_BITS'(READ_BURST_MAX);
      end else begin
         run_len = RUN_BITS'(run_min);
      end
   end

   assign load_rd = (state_ff == S_READ) && pend_ff && slot_free;
   assign issue   = (state_ff == S_READ) && (iss_left_ff != '0) && (!pend_ff || load_rd);

   always_comb begin
      state_in      = state_ff;
      in_use_in     = in_use_ff;
      tbl_we        = 1'b0;
      tbl_widx      = idx;
      tbl_rp        = rp_cur;
      tbl_wp        = wp_cur;
      tbl_fill      = fill_cur;
      burst_left_in = burst_left_ff;
      burst_acc_in  = burst_acc_ff;
      burst_ch_in   = burst_ch_ff;
      rd_ch_in      = rd_ch_ff;
      rd_pos_in     = rd_pos_ff;
      rd_cnt_in     = rd_cnt_ff;
      iss_left_in   = iss_left_ff;
      out_left_in   = out_left_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_item_in   = rsp_item_ff;
      store_req     = '0;

      if (accept) begin
         rsp_item_in = '{status: ST_OK, pipe_id: req_item.channel, byte_out: 8'd0,
                         count: '0, last: 1'b1};
         unique case (req_item.action)
            ACT_OPEN: begin
               rsp_valid_in = 1'b1;
               if (free_found) begin
                  in_use_in[free_idx] = 1'b1;
                  tbl_we   = 1'b1;
                  tbl_widx = free_idx;
                  tbl_rp   = '0;
                  tbl_wp   = '0;
                  tbl_fill = '0;
                  rsp_item_in.pipe_id = free_idx;
               end else begin
                  rsp_item_in.status  = ST_NO_FREE;
                  rsp_item_in.pipe_id = '0;
               end
            end
            ACT_CLOSE: begin
               rsp_valid_in = 1'b1;
               if (!chan_ok) begin
                  rsp_item_in.status = ST_BAD_CHAN;
               end else begin
                  in_use_in[req_item.channel] = 1'b0;
                  if (burst_left_ff != '0 && burst_ch_ff == req_item.channel) begin
                     burst_acc_in = 1'b0;
                  end
               end
            end
            ACT_WRITE: begin
               if (burst_left_ff != '0) begin
                  // Continuation bytes give no response.
                  burst_left_in = burst_left_ff - LEN_BITS'(1);
                  if (burst_acc_ff) begin
                     store_req.we    = 1'b1;
                     store_req.waddr = store_addr(idx, wp_cur);
                     store_req.wdata = req_item.data;
                     tbl_we   = 1'b1;
                     tbl_wp   = ptr_inc(wp_cur);
                     tbl_fill = fill_cur + FILL_BITS'(1);
                  end
                  if (burst_left_ff == LEN_BITS'(1)) begin
                     burst_acc_in = 1'b0;
                  end
               end else if (req_item.length != '0) begin
                  rsp_valid_in  = 1'b1;
                  burst_ch_in   = req_item.channel;
                  burst_left_in = req_item.length - LEN_BITS'(1);
                  burst_acc_in  = 1'b0;
                  if (!chan_ok) begin
                     rsp_item_in.status = ST_BAD_CHAN;
                  end else if ((11'(BUFFER_BYTES) - 11'(fill_cur)) < 11'(req_item.length)) begin
                     rsp_item_in.status = ST_NO_ROOM;
                  end else begin
                     burst_acc_in    = (req_item.length != LEN_BITS'(1));
                     store_req.we    = 1'b1;
                     store_req.waddr = store_addr(idx, wp_cur);
                     store_req.wdata = req_item.data;
                     tbl_we   = 1'b1;
                     tbl_wp   = ptr_inc(wp_cur);
                     tbl_fill = fill_cur + FILL_BITS'(1);
                     rsp_item_in.count = req_item.length;
                  end
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end
            ACT_READ: begin
               if (!chan_ok) begin
                  rsp_valid_in       = 1'b1;
                  rsp_item_in.status = ST_BAD_CHAN;
               end else if (req_item.length == '0) begin
                  rsp_valid_in = 1'b1;
               end else if (fill_cur == '0) begin
                  rsp_valid_in       = 1'b1;
                  rsp_item_in.status = ST_EMPTY;
               end else begin
                  // The table is advanced now; the sequencer walks the old read pointer.
                  state_in    = S_READ;
                  rd_ch_in    = req_item.channel;
                  rd_pos_in   = rp_cur;
                  rd_cnt_in   = run_len;
                  iss_left_in = run_len;
                  out_left_in = run_len;
                  tbl_we      = 1'b1;
                  tbl_rp      = ptr_add(rp_cur, run_len);
                  tbl_fill    = fill_cur - FILL_BITS'(run_len);
               end
            end
            default: begin
            end
         endcase
      end

      if (issue) begin
         store_req.re    = 1'b1;
         store_req.raddr = store_addr(rd_ch_ff, rd_pos_ff);
         rd_pos_in       = ptr_inc(rd_pos_ff);
         iss_left_in     = iss_left_ff - RUN_BITS'(1);
      end
      if (issue) begin
         pend_in = 1'b1;
      end else if (load_rd) begin
         pend_in = 1'b0;
      end
      if (load_rd) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = '{status: ST_OK, pipe_id: rd_ch_ff, byte_out: store_rdata,
                          count: LEN_BITS'(rd_cnt_ff),
                          last: (out_left_ff == RUN_BITS'(1))};
         out_left_in  = out_left_ff - RUN_BITS'(1);
         if (out_left_ff == RUN_BITS'(1)) begin
            state_in = S_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         in_use_ff     <= '0;
         burst_left_ff <= '0;
         burst_acc_ff  <= 1'b0;
         burst_ch_ff   <= '0;
         iss_left_ff   <= '0;
         out_left_ff   <= '0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < PIPE_COUNT; i++) begin
            rd_ptr_ff[i] <= '0;
            wr_ptr_ff[i] <= '0;
            fill_ff[i]   <= '0;
         end
      end else begin
         state_ff      <= state_in;
         in_use_ff     <= in_use_in;
         burst_left_ff <= burst_left_in;
         burst_acc_ff  <= burst_acc_in;
         burst_ch_ff   <= burst_ch_in;
         iss_left_ff   <= iss_left_in;
         out_left_ff   <= out_left_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (tbl_we) begin
            rd_ptr_ff[tbl_widx] <= tbl_rp;
            wr_ptr_ff[tbl_widx] <= tbl_wp;
            fill_ff[tbl_widx]   <= tbl_fill;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_ch_ff    <= rd_ch_in;
      rd_pos_ff   <= rd_pos_in;
      rd_cnt_ff   <= rd_cnt_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// ----- dv/pipe_scoreboard_pkg.sv -----
// Scoreboard class that predicts and checks byte pipe responses.
`timescale 1ns / 1ps

package pipe_scoreboard_pkg;
   import mcbp_pkg::*;

   class pipe_scoreboard;
      logic [7:0]           pipe_bytes [STORE_DEPTH];
      logic [PTR_BITS-1:0]  rd_ptr     [PIPE_COUNT];
      logic [PTR_BITS-1:0]  wr_ptr     [PIPE_COUNT];
      logic [FILL_BITS-1:0] fill       [PIPE_COUNT];
      bit                   is_open    [PIPE_COUNT];
      logic [LEN_BITS-1:0]  burst_left;
      bit                   burst_keep;
      logic [CH_BITS-1:0]   burst_chan;
      rsp_type              expected_q [$];
      int unsigned          mismatches;

      function new();
         for (int i = 0; i < PIPE_COUNT; i++) begin
            rd_ptr[i]  = '0;
            wr_ptr[i]  = '0;
            fill[i]    = '0;
            is_open[i] = 1'b0;
         end
         burst_left = '0;
         burst_keep = 1'b0;
         burst_chan = '0;
         mismatches = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void expect_rsp(logic [2:0] status, logic [CH_BITS-1:0] id, logic [7:0] b,
                               logic [LEN_BITS-1:0] cnt, logic lst);
         rsp_type r;
         r.status   = status;
         r.pipe_id  = id;
         r.byte_out = b;
         r.count    = cnt;
         r.last     = lst;
         expected_q.push_back(r);
      endfunction

      function void push_byte(logic [CH_BITS-1:0] ch, logic [7:0] b);
         pipe_bytes[int'(ch) * BUFFER_BYTES + int'(wr_ptr[ch])] = b;
         wr_ptr[ch] = (wr_ptr[ch] == PTR_BITS'(BUFFER_BYTES - 1)) ? '0 : wr_ptr[ch] + 1'b1;
         fill[ch]   = fill[ch] + 1'b1;
      endfunction

      // Works out the responses that one accepted request causes.
      function void note_request(req_type r);
         int                 found;
         int                 n;
         logic [7:0]         b;
         logic [CH_BITS-1:0] ch;
         found = -1;
         ch    = r.channel;
         case (r.action)
            ACT_OPEN: begin
               for (int i = 0; i < PIPE_COUNT; i++)
                  if (found < 0 && !is_open[i]) found = i;
               if (found < 0) begin
                  expect_rsp(ST_NO_FREE, '0, '0, '0, 1'b1);
               end else begin
                  is_open[found] = 1'b1;
                  rd_ptr[found]  = '0;
                  wr_ptr[found]  = '0;
                  fill[found]    = '0;
                  expect_rsp(ST_OK, CH_BITS'(found), '0, '0, 1'b1);
               end
            end
            ACT_CLOSE: begin
               if (!is_open[ch]) begin
                  expect_rsp(ST_BAD_CHAN, ch, '0, '0, 1'b1);
               end else begin
                  is_open[ch] = 1'b0;
                  if (burst_left != 0 && burst_chan == ch) burst_keep = 1'b0;
                  expect_rsp(ST_OK, ch, '0, '0, 1'b1);
               end
            end
            ACT_WRITE: begin
               if (burst_left != 0) begin
                  // Continuation bytes belong to the running burst whatever they carry.
                  burst_left = burst_left - 1'b1;
                  if (burst_keep) push_byte(burst_chan, r.data);
                  if (burst_left == 0) burst_keep = 1'b0;
               end else if (r.length == 0) begin
                  expect_rsp(ST_OK, ch, '0, '0, 1'b1);
               end else begin
                  burst_chan = ch;
                  burst_left = r.length - 1'b1;
                  if (!is_open[ch]) begin
                     burst_keep = 1'b0;
                     expect_rsp(ST_BAD_CHAN, ch, '0, '0, 1'b1);
                  end else if (BUFFER_BYTES - int'(fill[ch]) < int'(r.length)) begin
                     burst_keep = 1'b0;
                     expect_rsp(ST_NO_ROOM, ch, '0, '0, 1'b1);
                  end else begin
                     burst_keep = (burst_left != 0);
                     push_byte(ch, r.data);
                     expect_rsp(ST_OK, ch, '0, r.length, 1'b1);
                  end
               end
            end
            default: begin
               if (!is_open[ch]) begin
                  expect_rsp(ST_BAD_CHAN, ch, '0, '0, 1'b1);
               end else if (r.length == 0) begin
                  expect_rsp(ST_OK, ch, '0, '0, 1'b1);
               end else if (fill[ch] == 0) begin
                  expect_rsp(ST_EMPTY, ch, '0, '0, 1'b1);
               end else begin
                  n = int'(fill[ch]);
                  if (int'(r.length) < n) n = int'(r.length);
                  if (READ_BURST_MAX < n) n = READ_BURST_MAX;
                  for (int i = 0; i < n; i++) begin
                     b = pipe_bytes[int'(ch) * BUFFER_BYTES + int'(rd_ptr[ch])];
                     rd_ptr[ch] = (rd_ptr[ch] == PTR_BITS'(BUFFER_BYTES - 1)) ?
                                  '0 : rd_ptr[ch] + 1'b1;
                     expect_rsp(ST_OK, ch, b, LEN_BITS'(n), i + 1 == n);
                  end
                  fill[ch] = fill[ch] - FILL_BITS'(n);
               end
            end
         endcase
      endfunction

      function void check_field(string name, logic [LEN_BITS-1:0] want,
                                logic [LEN_BITS-1:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            $display("%0t: response with none expected, expected nothing, actual %h",
                     $time, got);
            mismatches++;
            return;
         end
         want = expected_q.pop_front();
         check_field("status", want.status, got.status);
         check_field("pipe_id", want.pipe_id, got.pipe_id);
         check_field("byte_out", want.byte_out, got.byte_out);
         check_field("count", want.count, got.count);
         check_field("last", want.last, got.last);
      endfunction
   endclass

endpackage

// ----- dv/testbench.sv -----
// Top-level testbench that drives and checks the multi-channel byte pipe.
`timescale 1ns / 1ps

module testbench;
   import mcbp_pkg::*;
   import pipe_scoreboard_pkg::*;

   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int PHASE_ITEMS    = 32;
   localparam int DRAIN_CYCLES   = 2 * READ_BURST_MAX + 8;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_item  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_item;

   pipe_scoreboard          sb;
   logic [PIPE_COUNT-1:0]   open_mask    = '0;
   int                      send_idle_pct = 0;
   int                      stall_pct     = 0;
   int                      items_sent    = 0;
   int                      hold_token    = 0;
   int                      hold_seen     = 0;
   int                      hold_left     = 0;
   int unsigned             quiet_cycles  = 0;

   multi_channel_byte_pipe dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) sb.note_request(req_item);
      if (!reset && rsp_valid && rsp_ready) sb.check_response(rsp_item);
   end

   // A change of hold_token starts one long hold-off of the response channel.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_token != hold_seen) begin
         hold_seen <= hold_token;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired with %0d responses outstanding", $time,
                  sb.pending());
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_request(input req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   // Sends one request and keeps the local view of which pipes are open.
   task automatic issue(input logic [1:0] action, input logic [CH_BITS-1:0] ch,
                        input logic [LEN_BITS-1:0] len, input logic [7:0] data);
      req_type item;
      int      slot;
      item.action  = action;
      item.channel = ch;
      item.length  = len;
      item.data    = data;
      slot = -1;
      send_request(item);
      if (action == ACT_OPEN) begin
         for (int i = 0; i < PIPE_COUNT; i++)
            if (slot < 0 && !open_mask[i]) slot = i;
         if (slot >= 0) open_mask[slot] = 1'b1;
      end else if (action == ACT_CLOSE) begin
         open_mask[ch] = 1'b0;
      end
   endtask

   function automatic logic [CH_BITS-1:0] pick_channel();
      logic [CH_BITS-1:0] ch;
      ch = CH_BITS'($urandom_range(PIPE_COUNT - 1));
      if (open_mask != '0 && $urandom_range(99) < 85)
         while (!open_mask[ch]) ch = CH_BITS'($urandom_range(PIPE_COUNT - 1));
      return ch;
   endfunction

   task automatic control_op();
      int roll;
      int open_weight;
      roll = $urandom_range(99);
      open_weight = ($countones(open_mask) < 3) ? 40 : 12;
      if (roll < open_weight)
         issue(ACT_OPEN, CH_BITS'($urandom_range(7)), LEN_BITS'($urandom_range(1023)),
               8'($urandom_range(255)));
      else if (roll < open_weight + 18)
         issue(ACT_CLOSE, pick_channel(), LEN_BITS'($urandom_range(1023)),
               8'($urandom_range(255)));
      else if ($urandom_range(99) < 12)
         issue(ACT_READ, pick_channel(), LEN_BITS'($urandom_range(1023)),
               8'($urandom_range(255)));
      else
         issue(ACT_READ, pick_channel(), LEN_BITS'($urandom_range(40)),
               8'($urandom_range(255)));
   endtask

   // The first request carries the burst length; the rest carry random channel and length.
   task automatic write_burst(input logic [CH_BITS-1:0] ch, input int len, input int mix_pct);
      issue(ACT_WRITE, ch, LEN_BITS'(len), 8'($urandom_range(255)));
      for (int i = 1; i < len; i++) begin
         if ($urandom_range(99) < mix_pct) control_op();
         issue(ACT_WRITE, CH_BITS'($urandom_range(7)), LEN_BITS'($urandom_range(1023)),
               8'($urandom_range(255)));
      end
   endtask

   task automatic random_op();
      int roll;
      int len;
      roll = $urandom_range(99);
      if (roll < 5)      len = 0;
      else if (roll < 85) len = $urandom_range(12, 1);
      else               len = $urandom_range(48, 13);
      if ($urandom_range(99) < 45) write_burst(pick_channel(), len, 8);
      else control_op();
   endtask

   initial begin
      int target;
      sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed requests against closed, empty and full cases.
      issue(ACT_READ, 3'd0, 10'd8, 8'h00);
      issue(ACT_CLOSE, 3'd5, 10'd0, 8'h00);
      issue(ACT_WRITE, 3'd2, 10'd2, 8'h11);
      issue(ACT_WRITE, 3'd2, 10'd0, 8'h22);
      issue(ACT_OPEN, 3'd7, 10'd1023, 8'hFF);
      issue(ACT_READ, 3'd0, 10'd3, 8'h00);
      issue(ACT_READ, 3'd0, 10'd0, 8'h00);
      issue(ACT_WRITE, 3'd0, 10'd0, 8'h33);
      issue(ACT_WRITE, 3'd0, 10'd4, 8'h00);
      issue(ACT_WRITE, 3'd7, 10'd1023, 8'hFF);
      issue(ACT_WRITE, 3'd7, 10'd1023, 8'hA5);
      issue(ACT_WRITE, 3'd5, 10'd512, 8'h5A);
      issue(ACT_READ, 3'd0, 10'd1023, 8'h00);
      repeat (8) issue(ACT_OPEN, 3'd0, 10'd0, 8'h00);
      // Closing a pipe in the middle of its burst drops the remaining bytes.
      issue(ACT_WRITE, 3'd1, 10'd3, 8'h44);
      issue(ACT_CLOSE, 3'd1, 10'd0, 8'h00);
      issue(ACT_WRITE, 3'd1, 10'd0, 8'h55);
      issue(ACT_WRITE, 3'd1, 10'd0, 8'h66);
      issue(ACT_READ, 3'd1, 10'd4, 8'h00);
      issue(ACT_OPEN, 3'd0, 10'd0, 8'h00);
      issue(ACT_READ, 3'd1, 10'd1, 8'h00);

      // Fill one pipe past a maximum-size read, then drain it.
      issue(ACT_CLOSE, 3'd2, 10'd0, 8'h00);
      issue(ACT_OPEN, 3'd0, 10'd0, 8'h00);
      write_burst(3'd2, 70, 0);
      repeat (2) issue(ACT_READ, 3'd2, 10'd64, 8'h00);

      // Hold off responses while requests keep coming so that the pipe backs up.
      write_burst(3'd3, 20, 0);
      hold_token++;
      repeat (10) issue(ACT_READ, 3'd3, 10'd4, 8'h00);
      repeat (10) control_op();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 88; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 88; end
            default: begin send_idle_pct = 8; stall_pct = 8; end
         endcase
         target = items_sent + PHASE_ITEMS;
         while (items_sent < target) random_op();
      end
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ----- files.f -----
design/mcbp_pkg.sv
design/mcbp_store.sv
design/mcbp_ctrl.sv
design/multi_channel_byte_pipe.sv
dv/pipe_scoreboard_pkg.sv
dv/testbench.sv
